FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/sle_pkg.sv
package sle_pkg;

  // List storage
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Transaction field widths
  localparam int MODE_W = 2;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 7;

  // Operation modes
  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOCATE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // Datapath operations, one per cycle
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] DP_NOP      = 4'd0;
  localparam logic [OP_W-1:0] DP_LOAD     = 4'd1;
  localparam logic [OP_W-1:0] DP_INS_RD   = 4'd2;
  localparam logic [OP_W-1:0] DP_INS_WR   = 4'd3;
  localparam logic [OP_W-1:0] DP_INS_PUT  = 4'd4;
  localparam logic [OP_W-1:0] DP_LOC_RD   = 4'd5;
  localparam logic [OP_W-1:0] DP_LOC_CMP  = 4'd6;
  localparam logic [OP_W-1:0] DP_REV_RDL  = 4'd7;
  localparam logic [OP_W-1:0] DP_REV_RDH  = 4'd8;
  localparam logic [OP_W-1:0] DP_REV_WRL  = 4'd9;
  localparam logic [OP_W-1:0] DP_REV_WRH  = 4'd10;
  localparam logic [OP_W-1:0] DP_RD_ISSUE = 4'd11;
  localparam logic [OP_W-1:0] DP_RD_TAKE  = 4'd12;

  // Controller to datapath
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            publish;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              err;
    logic              ins_more;
    logic              loc_more;
    logic              rev_more;
  } dp_stat_t;

endpackage

FILE: rtl/sle_if.sv
// Request channel
interface sle_req_if;
  import sle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink (input valid, input mode, input position, input value, output ready);
endinterface

// Response channel
interface sle_rsp_if;
  import sle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [POS_W-1:0]         found_position;
  logic signed [DATA_W-1:0] entry_value;
  logic [LEN_W-1:0]         list_length;

  modport source (output valid, output status, output found_position, output entry_value,
                  output list_length, input ready);
  modport sink (input valid, input status, input found_position, input entry_value,
                input list_length, output ready);
endinterface

FILE: rtl/sle_datapath.sv
module sle_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  sle_pkg::dp_cmd_t                 cmd,
  input  logic [sle_pkg::MODE_W-1:0]       mode,
  input  logic [sle_pkg::POS_W-1:0]        position,
  input  logic signed [sle_pkg::DATA_W-1:0] value,
  output sle_pkg::dp_stat_t                stat,
  output logic [sle_pkg::STAT_W-1:0]       status,
  output logic [sle_pkg::POS_W-1:0]        found_position,
  output logic signed [sle_pkg::DATA_W-1:0] entry_value,
  output logic [sle_pkg::LEN_W-1:0]        list_length
);
  import sle_pkg::*;

  // List storage, single write port and registered read port
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  // Working registers
  logic [CNT_W-1:0]  cnt;
  logic [MODE_W-1:0] mode_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  hi;
  logic [DATA_W-1:0] tmp;
  logic [STAT_W-1:0] st_w;
  logic [POS_W-1:0]  found_w;
  logic [DATA_W-1:0] entry_w;

  logic [STAT_W-1:0] err_in;
  logic [CNT_W-1:0]  idx_dec;
  logic [CNT_W-1:0]  pos_dec;

  assign idx_dec = idx - CNT_W'(1);
  assign pos_dec = CNT_W'(pos_r) - CNT_W'(1);

  // Up-front validity check of an incoming transaction
  always_comb begin
    err_in = ST_OK;
    case (mode)
      MODE_INSERT: begin
        if (cnt >= CNT_W'(CAPACITY)) begin
          err_in = ST_FULL;
        end else if (position == '0 ||
                     {1'b0, position} > ({1'b0, LEN_W'(cnt)} + 8'd1)) begin
          err_in = ST_RANGE;
        end
      end
      MODE_READ: begin
        if (position == '0 || {1'b0, position} > {1'b0, LEN_W'(cnt)}) begin
          err_in = ST_RANGE;
        end
      end
      default: err_in = ST_OK;
    endcase
  end

  // Memory port steering
  always_comb begin
    rd_addr = idx[ADDR_W-1:0];
    wr_addr = idx[ADDR_W-1:0];
    wr_data = rdata;
    wr_en   = 1'b0;
    case (cmd.op)
      DP_INS_RD:   rd_addr = idx_dec[ADDR_W-1:0];
      DP_INS_WR:   wr_en = 1'b1;
      DP_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_dec[ADDR_W-1:0];
        wr_data = val_r;
      end
      DP_REV_RDH:  rd_addr = hi[ADDR_W-1:0];
      DP_REV_WRL:  wr_en = 1'b1;
      DP_REV_WRH: begin
        wr_en   = 1'b1;
        wr_addr = hi[ADDR_W-1:0];
        wr_data = tmp;
      end
      DP_RD_ISSUE: rd_addr = pos_dec[ADDR_W-1:0];
      default:     rd_addr = idx[ADDR_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.op == DP_INS_PUT) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Operands, loop indexes and working result
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        mode_r  <= mode;
        pos_r   <= position;
        val_r   <= value;
        st_w    <= err_in;
        found_w <= '0;
        entry_w <= '0;
        idx     <= (mode == MODE_INSERT) ? cnt : '0;
        hi      <= cnt;
      end
      DP_INS_WR:  idx <= idx_dec;
      DP_LOC_CMP: begin
        if (rdata == val_r) begin
          found_w <= POS_W'(idx) + POS_W'(1);
        end
        idx <= idx + CNT_W'(1);
      end
      DP_REV_RDL: hi <= hi - CNT_W'(1);
      DP_REV_RDH: tmp <= rdata;
      DP_REV_WRH: idx <= idx + CNT_W'(1);
      DP_RD_TAKE: entry_w <= rdata;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      status         <= st_w;
      found_position <= found_w;
      entry_value    <= entry_w;
      list_length    <= LEN_W'(cnt);
    end
  end

  // Loop conditions for the controller
  always_comb begin
    stat.mode     = mode_r;
    stat.err      = (st_w != ST_OK);
    stat.ins_more = ({1'b0, LEN_W'(idx)} >= {1'b0, pos_r});
    stat.loc_more = (idx < cnt) && (found_w == '0);
    stat.rev_more = ({1'b0, hi} > ({1'b0, idx} + (CNT_W + 1)'(1)));
  end

endmodule

FILE: rtl/sle_ctrl.sv
module sle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  sle_pkg::dp_stat_t stat,
  output sle_pkg::dp_cmd_t  cmd
);
  import sle_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_WR  = 4'd3;
  localparam logic [3:0] S_LOC_RD  = 4'd4;
  localparam logic [3:0] S_LOC_CMP = 4'd5;
  localparam logic [3:0] S_REV_RDL = 4'd6;
  localparam logic [3:0] S_REV_RDH = 4'd7;
  localparam logic [3:0] S_REV_WRL = 4'd8;
  localparam logic [3:0] S_REV_WRH = 4'd9;
  localparam logic [3:0] S_RD_ISS  = 4'd10;
  localparam logic [3:0] S_RD_TAKE = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  // Sequencer
  always_comb begin
    state_next  = state;
    cmd.op      = DP_NOP;
    cmd.publish = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.err) begin
          state_next = S_FIN;
        end else begin
          case (stat.mode)
            MODE_INSERT:  state_next = S_INS_RD;
            MODE_LOCATE:  state_next = S_LOC_RD;
            MODE_REVERSE: state_next = S_REV_RDL;
            default:      state_next = S_RD_ISS;
          endcase
        end
      end
      // shift one entry up per pass, then drop the new value in
      S_INS_RD: begin
        if (stat.ins_more) begin
          cmd.op     = DP_INS_RD;
          state_next = S_INS_WR;
        end else begin
          cmd.op     = DP_INS_PUT;
          state_next = S_FIN;
        end
      end
      S_INS_WR: begin
        cmd.op     = DP_INS_WR;
        state_next = S_INS_RD;
      end
      // linear scan, stops at first hit
      S_LOC_RD: begin
        if (stat.loc_more) begin
          cmd.op     = DP_LOC_RD;
          state_next = S_LOC_CMP;
        end else begin
          state_next = S_FIN;
        end
      end
      S_LOC_CMP: begin
        cmd.op     = DP_LOC_CMP;
        state_next = S_LOC_RD;
      end
      // swap outer pair, walk inward
      S_REV_RDL: begin
        if (stat.rev_more) begin
          cmd.op     = DP_REV_RDL;
          state_next = S_REV_RDH;
        end else begin
          state_next = S_FIN;
        end
      end
      S_REV_RDH: begin
        cmd.op     = DP_REV_RDH;
        state_next = S_REV_WRL;
      end
      S_REV_WRL: begin
        cmd.op     = DP_REV_WRL;
        state_next = S_REV_WRH;
      end
      S_REV_WRH: begin
        cmd.op     = DP_REV_WRH;
        state_next = S_REV_RDL;
      end
      S_RD_ISS: begin
        cmd.op     = DP_RD_ISSUE;
        state_next = S_RD_TAKE;
      end
      S_RD_TAKE: begin
        cmd.op     = DP_RD_TAKE;
        state_next = S_FIN;
      end
      // wait for the output register to free up
      S_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Response valid
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.publish) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

FILE: rtl/sequential_list_engine.sv
// Response time grows with the entries shifted (insert), scanned (locate) or swapped
//   (reverse); a range or full error skips the list walk.
// Throughput: one transaction at a time; the next is taken in the cycle after the result
//   is loaded into the output register.
// Reset: synchronous, active high; empties the list and drops any pending response.
`include "assert_macros.svh"

module sequential_list_engine (
  input logic  clk,
  input logic  rst,
  sle_req_if.sink   req,
  sle_rsp_if.source rsp
);
  import sle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sle_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .mode           (req.mode),
    .position       (req.position),
    .value          (req.value),
    .stat           (stat),
    .status         (rsp.status),
    .found_position (rsp.found_position),
    .entry_value    (rsp.entry_value),
    .list_length    (rsp.list_length)
  );

  // Checks
  `SLE_ASSERT_IMP(a_len_cap, clk, rst, rsp.valid, rsp.list_length <= LEN_W'(CAPACITY))
  `SLE_ASSERT_IMP(a_found_in_list, clk, rst, rsp.valid, rsp.found_position <= rsp.list_length)
  `SLE_ASSERT_IMP(a_err_no_data, clk, rst, rsp.valid && rsp.status != ST_OK,
                  rsp.entry_value == 0 && rsp.found_position == 0)
  `SLE_ASSERT_NEXT(a_no_early_rsp, clk, rst, req.valid && req.ready, !$rose(rsp.valid))

endmodule
